// ===== hdl/utp_pkg.sv =====
package utp_pkg;

  // Text lengths that select a reading, and the saturation point of the count.
  localparam logic [5:0] RAW_LEN    = 6'd32;
  localparam logic [5:0] DASHED_LEN = 6'd36;
  localparam logic [5:0] COUNT_MAX  = 6'd63;

  // Positions of the separator characters in the dashed form.
  localparam logic [5:0] SEP_POS_0 = 6'd8;
  localparam logic [5:0] SEP_POS_1 = 6'd13;
  localparam logic [5:0] SEP_POS_2 = 6'd18;
  localparam logic [5:0] SEP_POS_3 = 6'd23;

  // Width of the packed result beat, filled up to whole bytes.
  localparam int OUT_DATA_W = 200;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_LEN = 2'd2,
    ST_BAD_HEX = 2'd3
  } utp_status_t;

  // One registered input beat.
  typedef struct packed {
    logic [7:0] char_in;
    logic       no_char;
    logic       last;
  } utp_beat_t;

  // One finished result.
  typedef struct packed {
    utp_status_t status;
    logic [63:0] hash_value;
    logic [63:0] uuid_high;
    logic [63:0] uuid_low;
  } utp_result_t;

endpackage

// ===== hdl/utp_in_reg.sv =====
module utp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // char_in
  input  logic              in_tuser,   // no_char
  input  logic              in_tlast,   // last
  input  logic              take,
  output logic              beat_valid,
  output utp_pkg::utp_beat_t beat
);
  import utp_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  utp_beat_t beat_r;

  // The register can load whenever it is empty or its beat leaves this cycle.
  assign in_tready = !valid_r || take;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      beat_r.char_in <= in_tdata;
      beat_r.no_char <= in_tuser;
      beat_r.last    <= in_tlast;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule

// ===== hdl/utp_accum.sv =====
module utp_accum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 beat_valid,
  input  utp_pkg::utp_beat_t   beat,
  input  logic                 out_free,
  output logic                 take,
  output logic                 res_load,
  output utp_pkg::utp_result_t result
);
  import utp_pkg::*;

  logic [5:0]   count_r;
  logic [5:0]   count_nxt;
  logic [127:0] raw_r;
  logic [127:0] raw_nxt;
  logic [127:0] dashed_r;
  logic [127:0] dashed_nxt;
  logic         raw_bad_r;
  logic         raw_bad_nxt;
  logic         dashed_bad_r;
  logic         dashed_bad_nxt;

  logic [3:0]   nib;
  logic         is_hex;
  logic         raw_en;
  logic         dash_en;
  logic         sep_pos;
  logic [5:0]   dash_idx;
  logic [5:0]   cnt_upd;
  logic [127:0] raw_upd;
  logic [127:0] dashed_upd;
  logic         raw_bad_upd;
  logic         dashed_bad_upd;
  logic [63:0]  res_lo;
  logic [63:0]  res_hi;

  // A last beat leaves only when the result register can take its result.
  assign take     = beat_valid && (!beat.last || out_free);
  assign res_load = take && beat.last;

  // Hex digit decode, either case.
  always_comb begin
    nib    = 4'd0;
    is_hex = 1'b1;
    case (beat.char_in) inside
      [8'h30:8'h39]: nib = 4'(beat.char_in - 8'h30);
      [8'h61:8'h66]: nib = 4'(beat.char_in - 8'h57);
      [8'h41:8'h46]: nib = 4'(beat.char_in - 8'h37);
      default:       is_hex = 1'b0;
    endcase
  end

  // Which reading the current position belongs to, and the dashed digit index.
  always_comb begin
    sep_pos = (count_r == SEP_POS_0) || (count_r == SEP_POS_1) ||
              (count_r == SEP_POS_2) || (count_r == SEP_POS_3);
    raw_en  = !beat.no_char && (count_r < RAW_LEN);
    dash_en = !beat.no_char && (count_r < DASHED_LEN) && !sep_pos;
    if (count_r > SEP_POS_3) begin
      dash_idx = count_r - 6'd4;
    end else if (count_r > SEP_POS_2) begin
      dash_idx = count_r - 6'd3;
    end else if (count_r > SEP_POS_1) begin
      dash_idx = count_r - 6'd2;
    end else if (count_r > SEP_POS_0) begin
      dash_idx = count_r - 6'd1;
    end else begin
      dash_idx = count_r;
    end
  end

  // Nibble insert: digit 2k is the high nibble of byte k, digit 2k+1 the low one.
  always_comb begin
    raw_upd        = raw_r;
    dashed_upd     = dashed_r;
    raw_bad_upd    = raw_bad_r || (raw_en && !is_hex);
    dashed_bad_upd = dashed_bad_r || (dash_en && !is_hex);
    for (int k = 0; k < 32; k++) begin
      if (raw_en && is_hex && (count_r[4:0] == 5'(k))) begin
        raw_upd[((k >> 1) * 8) + ((k & 1) != 0 ? 0 : 4) +: 4] = nib;
      end
      if (dash_en && is_hex && (dash_idx[4:0] == 5'(k))) begin
        dashed_upd[((k >> 1) * 8) + ((k & 1) != 0 ? 0 : 4) +: 4] = nib;
      end
    end
    if (!beat.no_char && (count_r != COUNT_MAX)) begin
      cnt_upd = count_r + 6'd1;
    end else begin
      cnt_upd = count_r;
    end
  end

  // Final length picks the reading.
  always_comb begin
    res_lo        = 64'd0;
    res_hi        = 64'd0;
    result.status = ST_OK;
    if (cnt_upd == 6'd0) begin
      result.status = ST_EMPTY;
    end else if (cnt_upd == RAW_LEN) begin
      if (raw_bad_upd) begin
        result.status = ST_BAD_HEX;
      end else begin
        res_lo = raw_upd[63:0];
        res_hi = raw_upd[127:64];
      end
    end else if (cnt_upd == DASHED_LEN) begin
      if (dashed_bad_upd) begin
        result.status = ST_BAD_HEX;
      end else begin
        res_lo = dashed_upd[63:0];
        res_hi = dashed_upd[127:64];
      end
    end else begin
      result.status = ST_BAD_LEN;
    end
    result.uuid_low   = res_lo;
    result.uuid_high  = res_hi;
    result.hash_value = res_lo ^ {res_hi[62:0], res_hi[63]};
  end

  // State advances on every beat that leaves and clears after a result.
  always_comb begin
    count_nxt      = count_r;
    raw_nxt        = raw_r;
    dashed_nxt     = dashed_r;
    raw_bad_nxt    = raw_bad_r;
    dashed_bad_nxt = dashed_bad_r;
    if (res_load) begin
      count_nxt      = 6'd0;
      raw_nxt        = 128'd0;
      dashed_nxt     = 128'd0;
      raw_bad_nxt    = 1'b0;
      dashed_bad_nxt = 1'b0;
    end else if (take) begin
      count_nxt      = cnt_upd;
      raw_nxt        = raw_upd;
      dashed_nxt     = dashed_upd;
      raw_bad_nxt    = raw_bad_upd;
      dashed_bad_nxt = dashed_bad_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= 6'd0;
      raw_r        <= 128'd0;
      dashed_r     <= 128'd0;
      raw_bad_r    <= 1'b0;
      dashed_bad_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      raw_r        <= raw_nxt;
      dashed_r     <= dashed_nxt;
      raw_bad_r    <= raw_bad_nxt;
      dashed_bad_r <= dashed_bad_nxt;
    end
  end

endmodule

// ===== hdl/utp_out_reg.sv =====
module utp_out_reg (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  res_load,
  input  utp_pkg::utp_result_t                  result,
  output logic                                  out_free,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [utp_pkg::OUT_DATA_W-1:0]        out_tdata
);
  import utp_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  utp_result_t res_r;

  // A new result may enter when the register is empty or drains this cycle.
  assign out_free  = !valid_r || out_tready;
  assign valid_nxt = res_load ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, res_r.status, res_r.hash_value, res_r.uuid_high, res_r.uuid_low};

endmodule

// ===== hdl/uuid_text_parser_core.sv =====
// Channel  Direction  Beat content
// in_      slave      tdata: char_in; tuser: no_char; tlast: last
// out_     master     tdata: uuid_low, uuid_high, hash_value, status
//
// One character beat is taken per cycle while no last beat waits on a stalled result;
// a result passes through the input register and then the result register.
// Reset (rst_n low, synchronous) clears the count, both readings and both valids.
// A stalled result stops only beats that carry tlast; other characters keep
// flowing into the accumulator until a last beat waits in the input register.
module uuid_text_parser_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] char_in
  input  logic                           in_tuser,   // [0] no_char
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [utp_pkg::OUT_DATA_W-1:0] out_tdata   // [63:0] uuid_low, [127:64] uuid_high,
                                                     // [191:128] hash_value, [193:192] status
);
  import utp_pkg::*;

  logic        beat_valid;
  utp_beat_t   beat;
  logic        take;
  logic        res_load;
  logic        out_free;
  utp_result_t result;

  utp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .take       (take),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  utp_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (beat_valid),
    .beat       (beat),
    .out_free   (out_free),
    .take       (take),
    .res_load   (res_load),
    .result     (result)
  );

  utp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_load   (res_load),
    .result     (result),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // The input side only stalls behind a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a pending result");

  // A result appears only after a last beat left the accumulator.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(take && beat.last))
    else $error("result without a last beat");

  // Any failing status carries an all-zero UUID and hash.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[193:192] != ST_OK)) |-> (out_tdata[191:0] == 192'd0))
    else $error("failing status with nonzero payload");

endmodule
